### design/pwm_timer_setting_calculator_top_defines.svh
// Assertion macros shared by the PWM timer setting calculator RTL.
// Included by the modules that check their own sequencing; no other dependencies.
`ifndef PWM_TIMER_SETTING_CALCULATOR_TOP_DEFINES_SVH
`define PWM_TIMER_SETTING_CALCULATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define PTSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pwm timer calculator: same-cycle check failed");
// Next-cycle implication, disabled during reset
`define PTSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pwm timer calculator: next-cycle check failed");
`else
`define PTSC_ASSERT_NOW(label, clk, rst, ante, cons)
`define PTSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/pwm_tsc_pkg.sv
// Shared widths, constants, status codes and interface structs of the
// PWM timer setting calculator. No dependencies.
package pwm_tsc_pkg;

   localparam int CLK_W      = 30;
   localparam int FREQ_W     = 32;
   localparam int DUTY_W     = 16;
   localparam int HOLD_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int NUM_W      = CLK_W + 8;     // clock_hz * 256
   localparam int DVS_W      = 48;            // p1 * freq fits in 48 bits
   localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
   localparam int P1_W       = 17;
   localparam int MAG_W      = 15;
   localparam int PROD_W     = HOLD_W + MAG_W;
   localparam int RECIP_W    = 24;
   localparam int RECIP_SHIFT = 30;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   localparam logic [CLK_W-1:0]   CLOCK_RESET = 30'd170000000;
   localparam logic [P1_W-1:0]    P1_MAX      = 17'd65536;
   localparam logic [MAG_W-1:0]   DUTY_FULL   = 15'd25600;
   // ceil(2^30 / 100): exact floor division by 100 for 23-bit operands
   localparam logic [RECIP_W-1:0] RECIP_100   = 24'd10737419;

   // Result status codes
   localparam logic [STATUS_W-1:0] STS_ALL   = 3'd0;
   localparam logic [STATUS_W-1:0] STS_CMP   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_ZERO  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_IGN   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_CLAMP = 3'd4;

   // Operation codes
   localparam logic OP_FULL = 1'b0;
   localparam logic OP_DUTY = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic              done;
      logic              clamped;
      logic [HOLD_W-1:0] compare;
   } scale_res_type;

endpackage

### design/pwm_tsc_divider.sv
// Shared radix-2 restoring divider: one quotient bit per cycle.
// Depends on pwm_tsc_pkg and the assertion macro header.
`include "pwm_timer_setting_calculator_top_defines.svh"
module pwm_tsc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pwm_tsc_pkg::NUM_W-1:0] dividend,
   input  logic [pwm_tsc_pkg::DVS_W-1:0] divisor,
   output logic [pwm_tsc_pkg::NUM_W-1:0] quotient,
   output pwm_tsc_pkg::div_stat_type     stat
);
   import pwm_tsc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVS_W:0]       trial;
   logic [DVS_W:0]       diff;
   logic                 fits;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   // Sequence the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `PTSC_ASSERT_NOW(a_no_restart, clock, reset, start, !busy_ff)
   `PTSC_ASSERT_NOW(a_busy_count, clock, reset, busy_ff, cnt_ff != '0)
   `PTSC_ASSERT_NEXT(a_last_done, clock, reset,
      busy_ff && !start && cnt_ff == DIV_CNT_W'(1), done_ff && !busy_ff)

endmodule

### design/pwm_tsc_scale.sv
// Compare scaling: |duty| clamp, reload * magnitude, then divide by 25600
// through a shift and an exact reciprocal multiply. Depends on pwm_tsc_pkg.
module pwm_tsc_scale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [pwm_tsc_pkg::HOLD_W-1:0]       reload,
   input  logic signed [pwm_tsc_pkg::DUTY_W-1:0] duty,
   output pwm_tsc_pkg::scale_res_type           res
);
   import pwm_tsc_pkg::*;

   localparam int X_W = PROD_W - 8;              // product / 256
   localparam int R_W = X_W + RECIP_W;

   logic [2:0]        vld_ff, vld_in;
   logic [HOLD_W-1:0] rel_ff;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              clamp_ff, clamp_in;
   logic [PROD_W-1:0] prod_ff;
   logic [R_W-1:0]    recip_ff;
   logic [DUTY_W:0]   mag_full;

   // Take the magnitude and clamp it at full scale
   always_comb begin
      mag_full = duty[DUTY_W-1] ? ((DUTY_W+1)'(0) - {1'b1, duty}) : {1'b0, duty};
      clamp_in = (mag_full > (DUTY_W+1)'(DUTY_FULL));
      mag_in   = clamp_in ? DUTY_FULL : mag_full[MAG_W-1:0];
      vld_in   = {vld_ff[1:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (start) begin
         rel_ff   <= reload;
         mag_ff   <= mag_in;
         clamp_ff <= clamp_in;
      end
      // Multiply, then scale by the reciprocal of 100
      prod_ff  <= PROD_W'(rel_ff) * PROD_W'(mag_ff);
      recip_ff <= R_W'(prod_ff[PROD_W-1:8]) * R_W'(RECIP_100);
   end

   assign res.done    = vld_ff[2];
   assign res.clamped = clamp_ff;
   assign res.compare = recip_ff[RECIP_SHIFT +: HOLD_W];

endmodule

### design/pwm_timer_setting_calculator_top.sv
// Top level of the PWM timer setting calculator: stream ports, clock register,
// held timer settings and the sequencer. Depends on pwm_tsc_pkg, pwm_tsc_divider,
// pwm_tsc_scale and the assertion macro header.
//
// One request word is worked on at a time and req_tready is low meanwhile. A full
// write runs two 38-step divisions on the shared one-bit-per-cycle divider (clock*256
// by the frequency, then by prescaler+1 times the frequency), a multiply state
// between them and the three-stage compare scaler; the result is then loaded into
// the response register from the done state, and only after that can the next word
// be accepted. A duty-only write uses the scaler alone; a zero frequency or an
// ignored duty update goes straight to the done state. A new request is taken
// while the previous response word still waits on rsp_tready; a stalled response
// holds the next result in the done state until the output register frees. The
// clock register is written through csr_wr_en/csr_wr_data and resets to 170 MHz.
`include "pwm_timer_setting_calculator_top_defines.svh"
module pwm_timer_setting_calculator_top #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration: clock_hz
   input  logic                                 csr_wr_en,
   input  logic [pwm_tsc_pkg::CLK_W-1:0]        csr_wr_data,
   // request: [31:0] freq_q8, [47:32] duty_q8
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pwm_tsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request: [0] operation
   input  logic                                 req_tuser,
   // response: [15:0] prescaler, [31:16] reload, [47:32] compare, [50:48] status
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pwm_tsc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import pwm_tsc_pkg::*;

   localparam int SUM_W = NUM_W + 1;
   localparam logic [SUM_W-1:0] CMASK = SUM_W'((64'd1 << COUNTER_BITS) - 64'd1);
   localparam logic [HOLD_W-1:0] RMAX =
      (COUNTER_BITS >= HOLD_W) ? {HOLD_W{1'b1}} : HOLD_W'((64'd1 << COUNTER_BITS) - 64'd1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV1  = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_DIV2  = 6'b001000,
      ST_SCALE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [CLK_W-1:0]     clock_hz_ff;
   logic [HOLD_W-1:0]    held_prescaler_ff, held_prescaler_in;
   logic [HOLD_W-1:0]    held_reload_ff, held_reload_in;
   logic [HOLD_W-1:0]    held_compare_ff, held_compare_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 op_ff, op_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [DUTY_W-1:0]    duty_ff, duty_in;
   logic [P1_W-1:0]      p1_ff, p1_in;
   logic                 clamp_ff, clamp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic [FREQ_W-1:0]    req_freq;
   logic [DUTY_W-1:0]    req_duty;
   logic                 div_start;
   logic [DVS_W-1:0]     div_divisor;
   logic [NUM_W-1:0]     div_quo;
   div_stat_type         div_stat;
   logic                 scl_start;
   logic [HOLD_W-1:0]    scl_reload;
   logic [DUTY_W-1:0]    scl_duty;
   scale_res_type        scl_res;
   logic [SUM_W-1:0]     p1_sum;
   logic [SUM_W-1:0]     p1_full;
   logic [HOLD_W-1:0]    rel_c;
   logic                 rel_clamp;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_freq   = req_tdata[FREQ_W-1:0];
   assign req_duty   = req_tdata[FREQ_W +: DUTY_W];

   // Prescaler + 1 from the period, and reload from the second quotient
   always_comb begin
      p1_sum  = {1'b0, div_quo} + CMASK;
      p1_full = p1_sum >> COUNTER_BITS;
      rel_clamp = 1'b0;
      if (div_quo == '0) begin
         rel_c     = '0;
         rel_clamp = 1'b1;
      end else if ((div_quo - NUM_W'(1)) > NUM_W'(RMAX)) begin
         rel_c     = RMAX;
         rel_clamp = 1'b1;
      end else begin
         rel_c = HOLD_W'(div_quo - NUM_W'(1));
      end
   end

   // Sequencer
   always_comb begin
      state_in          = state_ff;
      held_prescaler_in = held_prescaler_ff;
      held_reload_in    = held_reload_ff;
      held_compare_in   = held_compare_ff;
      status_in         = status_ff;
      op_in             = op_ff;
      freq_in           = freq_ff;
      duty_in           = duty_ff;
      p1_in             = p1_ff;
      clamp_in          = clamp_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_data_in       = rsp_data_ff;
      div_start         = 1'b0;
      div_divisor       = {{(DVS_W-FREQ_W){1'b0}}, req_freq};
      scl_start         = 1'b0;
      scl_reload        = held_reload_ff;
      scl_duty          = duty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scl_duty = req_duty;
            if (req_accept) begin
               op_in    = req_tuser;
               freq_in  = req_freq;
               duty_in  = req_duty;
               clamp_in = 1'b0;
               if (req_tuser == OP_FULL) begin
                  if (req_freq == '0) begin
                     held_compare_in = '0;
                     status_in       = STS_ZERO;
                     state_in        = ST_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV1;
                  end
               end else if (held_reload_ff == '0) begin
                  status_in = STS_IGN;
                  state_in  = ST_DONE;
               end else begin
                  scl_start = 1'b1;
                  state_in  = ST_SCALE;
               end
            end
         end
         ST_DIV1: begin
            if (div_stat.done) begin
               if (p1_full == '0) begin
                  p1_in = P1_W'(1);
               end else if (p1_full > SUM_W'(P1_MAX)) begin
                  p1_in    = P1_MAX;
                  clamp_in = 1'b1;
               end else begin
                  p1_in = P1_W'(p1_full);
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            div_divisor = DVS_W'(p1_ff) * DVS_W'(freq_ff);
            div_start   = 1'b1;
            state_in    = ST_DIV2;
         end
         ST_DIV2: begin
            scl_reload = rel_c;
            if (div_stat.done) begin
               held_prescaler_in = HOLD_W'(p1_ff - P1_W'(1));
               held_reload_in    = rel_c;
               clamp_in          = clamp_ff || rel_clamp;
               scl_start         = 1'b1;
               state_in          = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (scl_res.done) begin
               held_compare_in = scl_res.compare;
               if (clamp_ff || scl_res.clamped) begin
                  status_in = STS_CLAMP;
               end else if (op_ff == OP_DUTY) begin
                  status_in = STS_CMP;
               end else begin
                  status_in = STS_ALL;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the response word once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({status_ff, held_compare_ff,
                                           held_reload_ff, held_prescaler_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         clock_hz_ff       <= CLOCK_RESET;
         held_prescaler_ff <= '0;
         held_reload_ff    <= '0;
         held_compare_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         held_prescaler_ff <= held_prescaler_in;
         held_reload_ff    <= held_reload_in;
         held_compare_ff   <= held_compare_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_wr_en) begin
            clock_hz_ff <= csr_wr_data;
         end
      end
      status_ff   <= status_in;
      op_ff       <= op_in;
      freq_ff     <= freq_in;
      duty_ff     <= duty_in;
      p1_ff       <= p1_in;
      clamp_ff    <= clamp_in;
      rsp_data_ff <= rsp_data_in;
   end

   pwm_tsc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({clock_hz_ff, 8'd0}),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   pwm_tsc_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scl_start),
      .reload (scl_reload),
      .duty   (scl_duty),
      .res    (scl_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `PTSC_ASSERT_NOW(a_div_done_state, clock, reset, div_stat.done,
      state_ff == ST_DIV1 || state_ff == ST_DIV2)
   `PTSC_ASSERT_NOW(a_scale_done_state, clock, reset, scl_res.done, state_ff == ST_SCALE)
   `PTSC_ASSERT_NOW(a_ignored_no_reload, clock, reset,
      state_ff == ST_DONE && status_ff == STS_IGN, held_reload_ff == '0)

endmodule
